>>> hw/rtl/troi_pkg.sv
// Package for the tiled rectangle overlap group indexer.
// Holds geometry constants and the input and result beat types; no dependencies.
`default_nettype none
package troi_pkg;
	localparam int TILE_COLS      = 8;
	localparam int TILE_ROWS      = 8;
	localparam int RECTS_PER_TILE = 64;
	localparam int TILE_EDGE      = 255;
	localparam int NUM_TILES      = TILE_COLS * TILE_ROWS;
	localparam int NUM_SLOTS      = NUM_TILES * RECTS_PER_TILE;
	localparam int TW             = $clog2(NUM_TILES);
	localparam int SW             = $clog2(NUM_SLOTS);
	localparam int CW             = $clog2(RECTS_PER_TILE + 1);
	localparam int XW             = $clog2(TILE_COLS);
	localparam int YW             = $clog2(TILE_ROWS);

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic              action;
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_top;
		logic signed [15:0] rect_right;
		logic signed [15:0] rect_bottom;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] group_index;
		logic        capacity_collapsed;
	} out_beat_t;
endpackage
`default_nettype wire

>>> hw/rtl/tiled_rect_overlap_group_index.sv
// Top level of the tiled rectangle overlap group indexer.
// Uses troi_pkg; holds tile state and rectangle slots in memories.
//
// Input beats arrive on in_valid/in_stall with in_data; results leave on
// out_valid/out_stall with out_data, exactly one result per input beat.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 is the viewport width, index 1 the viewport height. Writing either
// empties all tiles. The block handles one beat at a time and stalls meanwhile.
// A clear goes straight to the done step, which presents the result; a discarded
// rectangle passes through the prep step first. A kept rectangle passes through
// the prep and range setup steps; then each touched tile is loaded and, unless
// the rectangle fully covers it, its slots are scanned with one memory read per
// cycle; then each touched tile is loaded again and inserted, and the done step
// presents the result. The next beat is accepted once the block is back in its
// idle state. At reset all tiles are empty with baseline zero and the viewport
// is 2040 by 2040; per-tile valid bits make a clearing pass unnecessary. When
// the receiver stalls, the result waits in the output register while the next
// beat is taken and processed; the block holds in its last step only if its own
// result is ready before the waiting one has left.
`default_nettype none
module tiled_rect_overlap_group_index import troi_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_beat_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_beat_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic      cfg_index,
	input  wire logic [10:0] cfg_data
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_RANGE, ST_TLOAD, ST_TSTART, ST_SCAN, ST_SCAN_WAIT,
		ST_TNEXT, ST_ILOAD, ST_INS, ST_DONE
	} state_t;

	state_t state_q;
	logic [10:0] vw_q, vh_q;
	logic [15:0] base_mem [NUM_TILES];
	logic [15:0] max_mem [NUM_TILES];
	logic [CW-1:0] cnt_mem [NUM_TILES];
	logic [NUM_TILES-1:0] tile_vld_q;
	logic [15:0] base_rd_q, max_rd_q;
	logic [CW-1:0] cnt_rd_q;
	logic tvld_rd_q;
	logic [31:0] edge_mem [NUM_SLOTS];
	logic [15:0] grp_mem [NUM_SLOTS];
	logic [31:0] edge_rd_q;
	logic [15:0] grp_rd_q;
	logic rd_vld_q;

	logic signed [17:0] l_q, t_q, r_q, b_q;
	logic [11:0] ew_q, eh_q;
	logic [XW-1:0] sx_q, ex_q, x_q;
	logic [YW-1:0] sy_q, ey_q, y_q;
	logic [CW-1:0] slot_q;
	logic [16:0] best_q;
	logic [15:0] g_q;
	logic flag_q;
	logic signed [17:0] nl_q, nt_q, rr_q, bb_q;
	out_beat_t out_q;
	logic ov_q;

	logic [TW-1:0] tile;
	logic signed [17:0] tx, ty;
	logic signed [17:0] nl, nt, rr, bb;
	logic signed [17:0] il, it, ir, ib;
	logic [7:0] cl, ct, cr, cb;
	logic covers;
	logic [SW-1:0] rd_addr;
	logic [CW-1:0] cur_cnt;
	logic [15:0] cur_base, cur_max;
	logic tile_full;
	logic [15:0] new_base, new_max;
	logic [CW-1:0] new_cnt;
	logic hit;
	logic last_tile;

	function automatic logic [5:0] div_edge(input logic [11:0] v);
		logic [5:0] q;
		logic [20:0] p;
		logic [11:0] rem;
		p = 21'(v) * 21'd257;
		q = 6'(p >> 16);
		rem = v - 12'(q) * 12'd255;
		if (rem >= 12'd255)
			q = q + 6'd1;
		return q;
	endfunction

	function automatic logic signed [17:0] min18(input logic signed [17:0] a,
		input logic signed [17:0] b2);
		return (a < b2) ? a : b2;
	endfunction

	function automatic logic [7:0] clip8(input logic signed [17:0] v);
		logic [7:0] o;
		if (v < 0)
			o = 8'd0;
		else if (v > 18'sd254)
			o = 8'd254;
		else
			o = v[7:0];
		return o;
	endfunction

	assign tile = TW'({y_q, x_q}) ;
	assign tx = 18'(x_q) * 18'sd255;
	assign ty = 18'(y_q) * 18'sd255;
	assign nl = min18(18'sd255 - (l_q - tx), 18'sd255);
	assign nt = min18(18'sd255 - (t_q - ty), 18'sd255);
	assign rr = min18(r_q - tx, 18'sd255);
	assign bb = min18(b_q - ty, 18'sd255);
	assign il = l_q - tx;
	assign it = t_q - ty;
	assign ir = 18'sd255 - (r_q - tx);
	assign ib = 18'sd255 - (b_q - ty);
	assign cl = clip8(il);
	assign ct = clip8(it);
	assign cr = clip8(ir);
	assign cb = clip8(ib);
	assign covers = (cl == 8'd0) && (ct == 8'd0) && (cr == 8'd0) && (cb == 8'd0);
	assign cur_cnt = tvld_rd_q ? cnt_rd_q : '0;
	assign cur_base = tvld_rd_q ? base_rd_q : '0;
	assign cur_max = tvld_rd_q ? max_rd_q : '0;
	assign tile_full = !covers && (cur_cnt >= CW'(RECTS_PER_TILE));
	assign rd_addr = SW'({tile, slot_q[CW-2:0]});
	assign last_tile = (x_q == ex_q) && (y_q == ey_q);
	assign hit = ($signed({10'd0, edge_rd_q[7:0]}) < rr_q) &&
		($signed({10'd0, edge_rd_q[15:8]}) < bb_q) &&
		($signed({10'd0, edge_rd_q[23:16]}) < nl_q) &&
		($signed({10'd0, edge_rd_q[31:24]}) < nt_q);

	always_comb begin
		new_base = cur_base;
		new_max = cur_max;
		new_cnt = cur_cnt;
		if (covers) begin
			new_base = g_q;
			new_max = g_q;
			new_cnt = '0;
		end else if (tile_full) begin
			new_base = (cur_max > g_q) ? cur_max : g_q;
			new_max = (cur_max > g_q) ? cur_max : g_q;
			new_cnt = '0;
		end else begin
			if (g_q > cur_max)
				new_max = g_q;
			new_cnt = cur_cnt + CW'(1);
		end
	end

	assign in_stall = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = ov_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_INS) begin
			base_mem[tile] <= new_base;
			max_mem[tile] <= new_max;
			cnt_mem[tile] <= new_cnt;
			if (!covers && !tile_full) begin
				edge_mem[SW'({tile, cur_cnt[CW-2:0]})] <= {cb, cr, ct, cl};
				grp_mem[SW'({tile, cur_cnt[CW-2:0]})] <= g_q;
			end
		end
		edge_rd_q <= edge_mem[rd_addr];
		grp_rd_q <= grp_mem[rd_addr];
		base_rd_q <= base_mem[tile];
		max_rd_q <= max_mem[tile];
		cnt_rd_q <= cnt_mem[tile];
		tvld_rd_q <= tile_vld_q[tile];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vw_q <= 11'd2040;
			vh_q <= 11'd2040;
			ov_q <= 1'b0;
			out_q <= '0;
			rd_vld_q <= 1'b0;
			tile_vld_q <= '0;
		end else begin
			if (state_q == ST_DONE && (!ov_q || !out_stall))
				ov_q <= 1'b1;
			else if (ov_q && !out_stall)
				ov_q <= 1'b0;
			rd_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == CFG_WIDTH)
							vw_q <= cfg_data;
						else
							vh_q <= cfg_data;
						tile_vld_q <= '0;
					end else if (in_valid && !in_stall) begin
						l_q <= 18'($signed(in_data.rect_left));
						t_q <= 18'($signed(in_data.rect_top));
						r_q <= 18'($signed(in_data.rect_right));
						b_q <= 18'($signed(in_data.rect_bottom));
						ew_q <= (vw_q > 11'(TILE_COLS * TILE_EDGE)) ?
							12'(TILE_COLS * TILE_EDGE) : 12'(vw_q);
						eh_q <= (vh_q > 11'(TILE_ROWS * TILE_EDGE)) ?
							12'(TILE_ROWS * TILE_EDGE) : 12'(vh_q);
						g_q <= '0;
						flag_q <= 1'b0;
						best_q <= '0;
						if (in_data.action) begin
							tile_vld_q <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					if (ew_q == 12'd0 || eh_q == 12'd0 || l_q >= $signed({6'd0, ew_q}) ||
						t_q >= $signed({6'd0, eh_q}) || r_q <= 0 || b_q <= 0 ||
						l_q >= r_q || t_q >= b_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RANGE;
					end
				end
				ST_RANGE: begin
					logic [5:0] cols, rows, a, c;
					cols = div_edge(ew_q + 12'd254);
					rows = div_edge(eh_q + 12'd254);
					a = div_edge((l_q < 0) ? 12'd0 : l_q[11:0]);
					c = div_edge(t_q < 0 ? 12'd0 : t_q[11:0]);
					sx_q <= XW'((a > cols - 6'd1) ? cols - 6'd1 : a);
					sy_q <= YW'((c > rows - 6'd1) ? rows - 6'd1 : c);
					x_q <= XW'((a > cols - 6'd1) ? cols - 6'd1 : a);
					y_q <= YW'((c > rows - 6'd1) ? rows - 6'd1 : c);
					a = div_edge((r_q > 18'sd4095) ? 12'd4095 : 12'(r_q - 18'sd1));
					c = div_edge((b_q > 18'sd4095) ? 12'd4095 : 12'(b_q - 18'sd1));
					ex_q <= XW'((a > cols - 6'd1) ? cols - 6'd1 : a);
					ey_q <= YW'((c > rows - 6'd1) ? rows - 6'd1 : c);
					state_q <= ST_TLOAD;
				end
				ST_TLOAD: begin
					state_q <= ST_TSTART;
				end
				ST_TSTART: begin
					nl_q <= nl;
					nt_q <= nt;
					rr_q <= rr;
					bb_q <= bb;
					slot_q <= '0;
					if (nl == 18'sd255 && nt == 18'sd255 && rr == 18'sd255 &&
						bb == 18'sd255) begin
						if (17'(cur_max) > best_q && cur_max >= cur_base)
							best_q <= 17'(cur_max);
						else if (17'(cur_base) > best_q)
							best_q <= 17'(cur_base);
						state_q <= ST_TNEXT;
					end else begin
						if (17'(cur_base) > best_q)
							best_q <= 17'(cur_base);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_vld_q && hit && 17'(grp_rd_q) > best_q)
						best_q <= 17'(grp_rd_q);
					if (slot_q >= cur_cnt) begin
						state_q <= ST_SCAN_WAIT;
					end else begin
						rd_vld_q <= 1'b1;
						slot_q <= slot_q + CW'(1);
					end
				end
				ST_SCAN_WAIT: begin
					if (rd_vld_q && hit && 17'(grp_rd_q) > best_q)
						best_q <= 17'(grp_rd_q);
					state_q <= ST_TNEXT;
				end
				ST_TNEXT: begin
					if (last_tile) begin
						g_q <= (best_q >= 17'd65535) ? 16'hFFFF : 16'(best_q + 17'd1);
						x_q <= sx_q;
						y_q <= sy_q;
						state_q <= ST_ILOAD;
					end else begin
						if (x_q == ex_q) begin
							x_q <= sx_q;
							y_q <= y_q + YW'(1);
						end else begin
							x_q <= x_q + XW'(1);
						end
						state_q <= ST_TLOAD;
					end
				end
				ST_ILOAD: begin
					state_q <= ST_INS;
				end
				ST_INS: begin
					tile_vld_q[tile] <= 1'b1;
					if (tile_full)
						flag_q <= 1'b1;
					if (last_tile) begin
						state_q <= ST_DONE;
					end else begin
						if (x_q == ex_q) begin
							x_q <= sx_q;
							y_q <= y_q + YW'(1);
						end else begin
							x_q <= x_q + XW'(1);
						end
						state_q <= ST_ILOAD;
					end
				end
				ST_DONE: begin
					if (!ov_q || !out_stall) begin
						out_q.group_index <= g_q;
						out_q.capacity_collapsed <= flag_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !in_stall == 1'b0)
		else $error("accepted a beat while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cfg_ready)
		else $error("config taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result lost");
endmodule
`default_nettype wire
